[hdl/psv_pkg.sv]
// Package with the shared types, constants and the sine table of the voice engine.
package psv_pkg;

  // Default voice count and sine table size.
  localparam int unsigned NumVoicesDef = 8;
  localparam int unsigned SineAddrBits = 10;
  localparam int unsigned Quarter = 1 << (SineAddrBits - 2);

  // Envelope and mix constants.
  localparam logic [15:0] EnvFloor = 16'd33;
  localparam logic signed [17:0] MixFund = 18'sd26214;
  localparam logic signed [17:0] MixHarm = 18'sd4915;

  // Quarter-wave polynomial coefficients in Q30.
  localparam logic [63:0] Q30C1 = 64'd1686629713;
  localparam logic [63:0] Q30C3 = 64'd693598667;
  localparam logic [63:0] Q30C5 = 64'd85569311;
  localparam logic [63:0] Q30C7 = 64'd5026995;
  localparam logic [63:0] Q30C9 = 64'd172272;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_ON   = 2'd1,
    REQ_OFF  = 2'd2
  } psv_req_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_GAIN    = 2'd2
  } psv_cfg_e;

  // Input word.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  key;
    logic [15:0] phase_step;
  } psv_in_t;

  // Output word.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               clipped;
  } psv_out_t;

  // Configuration register set.
  typedef struct packed {
    logic [14:0] attack;
    logic [14:0] rel;
    logic [14:0] gain;
  } psv_cfg_t;

  // One voice entry as stored in memory.
  typedef struct packed {
    logic [7:0]  owner;
    logic        held;
    logic [15:0] step;
    logic [15:0] level;
    logic [15:0] phase;
  } psv_voice_t;

  localparam int unsigned VoiceW = $bits(psv_voice_t);

  typedef logic [15:0] psv_qsine_t [Quarter + 1];

  // Q30 product scaled back to Q30.
  function automatic logic [63:0] psv_mul_q30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // Builds the quarter-wave table at elaboration.
  function automatic psv_qsine_t psv_qsine_gen();
    psv_qsine_t tab;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] r;
    for (int k = 0; k <= Quarter; k++) begin
      t  = 64'(k) << (32 - SineAddrBits);
      t2 = psv_mul_q30(t, t);
      p  = Q30C7 - psv_mul_q30(t2, Q30C9);
      p  = Q30C5 - psv_mul_q30(t2, p);
      p  = Q30C3 - psv_mul_q30(t2, p);
      p  = Q30C1 - psv_mul_q30(t2, p);
      r  = (psv_mul_q30(t, p) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      tab[k] = r[15:0];
    end
    return tab;
  endfunction

  localparam psv_qsine_t QSine = psv_qsine_gen();

  // Full-wave sine lookup from a 16-bit phase, signed Q1.15.
  function automatic logic signed [15:0] psv_sine(input logic [15:0] phase);
    logic [SineAddrBits-1:0] idx;
    logic [SineAddrBits-2:0] a;
    logic [15:0]             v;
    idx = phase[15 -: SineAddrBits];
    a   = {1'b0, idx[SineAddrBits-3:0]};
    if (idx[SineAddrBits-2]) begin
      v = QSine[(SineAddrBits-1)'(Quarter) - a];
    end else begin
      v = QSine[a];
    end
    return idx[SineAddrBits-1] ? -$signed(v) : $signed(v);
  endfunction

endpackage

[hdl/polyphonic_sine_voice_engine.sv]
// Top level of the polyphonic sine voice engine: configuration, handshakes, sequencer.
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid_i/in_stall_o  | in_data_i (req_type, key, phase_step)
//  out     | output    | out_valid_o/out_stall_i| out_data_o (sample, clipped)
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_idx_i, cfg_data_i
//
// A tick, a note-on and a note-off each walk the voice memory one voice at a time, with one
// shared multiplier; a tick does more work for a sounding voice than for a silent one or one
// released to silence, and a note-on ends by claiming a voice unless the key is already held.
// Reset loads the default configuration and clears the sequencer and the per-voice valid bits.
// A new word is taken while a finished sample waits in the output register.
module polyphonic_sine_voice_engine #(
  parameter int unsigned NumVoices = psv_pkg::NumVoicesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  psv_pkg::psv_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psv_pkg::psv_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_idx_i,
  input  logic [14:0]       cfg_data_i
);
  import psv_pkg::*;

  psv_cfg_t cfg_q;
  logic     core_idle;
  logic     res_valid;
  psv_out_t res;
  logic     res_take;
  logic     out_valid_q;
  psv_out_t out_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack <= 15'd136;
      cfg_q.rel    <= 15'd32745;
      cfg_q.gain   <= 15'd4915;
    end else if (cfg_valid_i) begin
      if (cfg_idx_i == CFG_ATTACK) begin
        cfg_q.attack <= cfg_data_i;
      end else if (cfg_idx_i == CFG_RELEASE) begin
        cfg_q.rel <= cfg_data_i;
      end else if (cfg_idx_i == CFG_GAIN) begin
        cfg_q.gain <= cfg_data_i;
      end
    end
  end

  psv_core #(
    .NumVoices (NumVoices)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (in_valid_i),
    .item_i      (in_data_i),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign in_stall_o = !core_idle;

  // Output register, loaded when empty or being drained.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/psv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module psv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/psv_core.sv]
// Voice sequencer: walks the voice memory for ticks, note-ons and note-offs.
module psv_core #(
  parameter int unsigned NumVoices = psv_pkg::NumVoicesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psv_pkg::psv_cfg_t cfg_i,
  input  logic              start_i,
  input  psv_pkg::psv_in_t  item_i,
  output logic              idle_o,
  output logic              res_valid_o,
  output psv_pkg::psv_out_t res_o,
  input  logic              res_take_i
);
  import psv_pkg::*;

  localparam int unsigned VIdxW = (NumVoices > 1) ? $clog2(NumVoices) : 1;
  localparam int unsigned MixW = 17 + VIdxW;
  localparam logic [VIdxW-1:0] LastVoice = VIdxW'(NumVoices - 1);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_RD    = 12'b000000000010,
    ST_EVAL  = 12'b000000000100,
    ST_ENV   = 12'b000000001000,
    ST_W1    = 12'b000000010000,
    ST_W2    = 12'b000000100000,
    ST_W3    = 12'b000001000000,
    ST_TERM  = 12'b000010000000,
    ST_ADV   = 12'b000100000000,
    ST_RND   = 12'b001000000000,
    ST_OUT   = 12'b010000000000,
    ST_CLAIM = 12'b100000000000
  } psv_state_e;

  psv_state_e st_q, st_d;

  psv_in_t               item_q;
  logic [VIdxW-1:0]      vidx_q;
  logic [NumVoices-1:0]  vld_q;
  logic                  rd_vld_q;
  psv_voice_t            ent_q;
  logic [15:0]           lvl_q;
  logic [15:0]           phase_q;
  logic signed [31:0]    fund_q;
  logic signed [31:0]    wave_q;
  logic signed [MixW-1:0] mix_q;
  logic                  found_q;
  logic                  dup_q;
  logic [VIdxW-1:0]      best_q;
  logic [16:0]           best_lvl_q;
  psv_out_t              res_q;

  // Memory ports.
  logic             ram_we;
  logic [VIdxW-1:0] ram_waddr;
  psv_voice_t       ram_wdata;
  logic             ram_re;
  logic [VoiceW-1:0] ram_rdata;
  psv_voice_t       ent;

  // Shared multiplier.
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_q;

  // Envelope and phase results of the current voice.
  logic [15:0]        lvl_new;
  logic [15:0]        ph_new;
  logic               silent;
  logic signed [15:0] sin1;
  logic signed [15:0] sin2;
  logic signed [35:0] rnd;

  psv_ram #(
    .Width (VoiceW),
    .Depth (NumVoices)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (vidx_q),
    .rdata_o (ram_rdata)
  );

  // An entry never written reads as the reset value of zero.
  assign ent    = rd_vld_q ? psv_voice_t'(ram_rdata) : '0;
  assign silent = !ent.held && (ent.level < EnvFloor);

  // Envelope update from the multiplier product.
  always_comb begin
    if (ent_q.held) begin
      lvl_new = ent_q.level + 16'(mul_q[31:15]);
    end else begin
      lvl_new = mul_q[30:15];
    end
  end

  assign ph_new = ent_q.phase + ent_q.step;
  assign sin1   = psv_sine(ph_new);
  assign sin2   = psv_sine({phase_q[14:0], 1'b0});
  assign rnd    = 36'(mul_q + 51'sd16384) >>> 15;

  // Next state, memory control and multiplier operands.
  always_comb begin
    st_d      = st_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = vidx_q;
    ram_wdata = ent_q;
    mul_a     = '0;
    mul_b     = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (start_i && (item_i.req_type == REQ_TICK || item_i.req_type == REQ_ON ||
                        item_i.req_type == REQ_OFF)) begin
          st_d = ST_RD;
        end
      end
      ST_RD: begin
        ram_re = 1'b1;
        st_d   = ST_EVAL;
      end
      ST_EVAL: begin
        st_d = ST_ADV;
        if (item_q.req_type == REQ_TICK) begin
          if (!silent) begin
            st_d = ST_ENV;
            if (ent.held) begin
              mul_a = $signed({16'd0, 17'(17'h08000 - {1'b0, ent.level})});
              mul_b = $signed({3'd0, cfg_i.attack});
            end else begin
              mul_a = $signed({17'd0, ent.level});
              mul_b = $signed({3'd0, cfg_i.rel});
            end
          end
        end else if (item_q.req_type == REQ_OFF) begin
          if (ent.owner == item_q.key) begin
            ram_we         = 1'b1;
            ram_wdata      = ent;
            ram_wdata.held = 1'b0;
          end
        end
      end
      ST_ENV: begin
        ram_we = 1'b1;
        if (!ent_q.held && lvl_new < EnvFloor) begin
          ram_wdata.level = '0;
          st_d            = ST_ADV;
        end else begin
          ram_wdata.level = lvl_new;
          ram_wdata.phase = ph_new;
          mul_a           = 33'(sin1);
          mul_b           = MixFund;
          st_d            = ST_W1;
        end
      end
      ST_W1: begin
        mul_a = 33'(sin2);
        mul_b = MixHarm;
        st_d  = ST_W2;
      end
      ST_W2: begin
        st_d = ST_W3;
      end
      ST_W3: begin
        mul_a = 33'(wave_q);
        mul_b = $signed({2'd0, lvl_q});
        st_d  = ST_TERM;
      end
      ST_TERM: begin
        st_d = ST_ADV;
      end
      ST_ADV: begin
        if (vidx_q != LastVoice) begin
          st_d = ST_RD;
        end else if (item_q.req_type == REQ_TICK) begin
          mul_a = 33'(mix_q);
          mul_b = $signed({3'd0, cfg_i.gain});
          st_d  = ST_RND;
        end else if (item_q.req_type == REQ_ON && !dup_q) begin
          st_d = ST_CLAIM;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_RND: begin
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (res_take_i) begin
          st_d = ST_IDLE;
        end
      end
      ST_CLAIM: begin
        ram_we          = 1'b1;
        ram_waddr       = best_q;
        ram_wdata.owner = item_q.key;
        ram_wdata.held  = 1'b1;
        ram_wdata.step  = item_q.phase_step;
        ram_wdata.level = best_lvl_q[15:0];
        ram_wdata.phase = '0;
        st_d            = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_q <= vld_q[vidx_q];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    unique case (st_q)
      ST_IDLE: begin
        item_q     <= item_i;
        vidx_q     <= '0;
        mix_q      <= '0;
        found_q    <= 1'b0;
        dup_q      <= 1'b0;
        best_q     <= '0;
        best_lvl_q <= '1;
      end
      ST_EVAL: begin
        ent_q <= ent;
        if (ent.held && ent.owner == item_q.key) begin
          dup_q <= 1'b1;
        end
        // First idle and silent voice wins, otherwise the quietest one.
        if (!found_q) begin
          if (silent) begin
            found_q    <= 1'b1;
            best_q     <= vidx_q;
            best_lvl_q <= {1'b0, ent.level};
          end else if ({1'b0, ent.level} < best_lvl_q) begin
            best_q     <= vidx_q;
            best_lvl_q <= {1'b0, ent.level};
          end
        end
      end
      ST_ENV: begin
        lvl_q   <= lvl_new;
        phase_q <= ph_new;
      end
      ST_W1: begin
        fund_q <= 32'(mul_q);
      end
      ST_W2: begin
        wave_q <= fund_q + 32'(mul_q);
      end
      ST_TERM: begin
        mix_q <= mix_q + MixW'((mul_q + 51'sd536870912) >>> 30);
      end
      ST_ADV: begin
        vidx_q <= vidx_q + VIdxW'(1);
      end
      ST_RND: begin
        if (rnd > 36'sd32767) begin
          res_q.sample  <= 16'sd32767;
          res_q.clipped <= 1'b1;
        end else if (rnd < -36'sd32768) begin
          res_q.sample  <= -16'sd32768;
          res_q.clipped <= 1'b1;
        end else begin
          res_q.sample  <= 16'(rnd);
          res_q.clipped <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle_o      = (st_q == ST_IDLE);
  assign res_valid_o = (st_q == ST_OUT);
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // The memory is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("voice memory read and write collide");

  // A voice read is always followed by its evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_re |=> st_q == ST_EVAL)
    else $error("read data not consumed");

  // A sounding voice level stays below full scale after the envelope step.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (st_q == ST_W1) |-> !lvl_q[15])
    else $error("envelope level overflow");

  // A claim only happens when no held voice owns the key.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (st_q == ST_CLAIM) |-> !dup_q)
    else $error("duplicate key claimed");
`endif

endmodule

[test/testbench.sv]
// Self-checking testbench for the polyphonic sine voice engine.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import psv_pkg::*;

  localparam int NV = 8;
  localparam int unsigned MaxCycles = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  psv_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  psv_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_idx = '0;
  logic [14:0] cfg_data = '0;

  polyphonic_sine_voice_engine dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted voice state and register copy.
  logic [15:0] v_phase [NV];
  logic [15:0] v_level [NV];
  logic [15:0] v_step [NV];
  logic v_held [NV];
  logic [7:0] v_owner [NV];
  logic [14:0] attack_q, release_q, gain_q;

  psv_in_t pending_words [$];
  psv_out_t expected_samples [$];
  int errors = 0;
  int samples_seen = 0;
  int words_sent = 0;
  int cycle_count = 0;
  logic hold_off = 1'b0;

  // Quarter-wave sine value in Q15, built from the polynomial.
  function automatic logic [63:0] mq(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic int quarter_wave(input int unsigned a);
    logic [63:0] t, t2, p, r;
    t = 64'(a) << 22;
    t2 = mq(t, t);
    p = 64'd5026995 - mq(t2, 64'd172272);
    p = 64'd85569311 - mq(t2, p);
    p = 64'd693598667 - mq(t2, p);
    p = 64'd1686629713 - mq(t2, p);
    r = (mq(t, p) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return int'(r);
  endfunction

  function automatic int wave_at(input logic [15:0] ph);
    int unsigned idx, quad, a;
    int v;
    idx = ph >> 6;
    quad = idx >> 8;
    a = idx & 255;
    v = quad[0] ? quarter_wave(256 - a) : quarter_wave(a);
    return quad[1] ? -v : v;
  endfunction

  function automatic longint floor_div(input longint x, input int n);
    return x >>> n;
  endfunction

  function automatic logic is_silent(input int v);
    return !v_held[v] && v_level[v] < 16'd33;
  endfunction

  // Applies one word to the voice state; returns 1 with a sample on a tick.
  function automatic bit voice_engine_step(input psv_in_t w, output psv_out_t s);
    int best;
    int unsigned best_lvl, lvl;
    longint mix, res, wave;
    s = '0;
    if (w.req_type == REQ_ON) begin
      for (int v = 0; v < NV; v++)
        if (v_held[v] && v_owner[v] == w.key) return 0;
      best = 0;
      best_lvl = 32'h20000;
      for (int v = 0; v < NV; v++) begin
        if (is_silent(v)) begin
          best = v;
          break;
        end
        if (v_level[v] < best_lvl) begin
          best_lvl = v_level[v];
          best = v;
        end
      end
      v_step[best] = w.phase_step;
      v_phase[best] = '0;
      v_held[best] = 1'b1;
      v_owner[best] = w.key;
      return 0;
    end
    if (w.req_type == REQ_OFF) begin
      for (int v = 0; v < NV; v++)
        if (v_owner[v] == w.key) v_held[v] = 1'b0;
      return 0;
    end
    if (w.req_type != REQ_TICK) return 0;
    mix = 0;
    for (int v = 0; v < NV; v++) begin
      if (is_silent(v)) continue;
      lvl = v_level[v];
      if (v_held[v]) begin
        lvl = lvl + (((32768 - lvl) * attack_q) >> 15);
      end else begin
        lvl = (lvl * release_q) >> 15;
        if (lvl < 33) begin
          v_level[v] = '0;
          continue;
        end
      end
      v_level[v] = lvl[15:0];
      v_phase[v] = v_phase[v] + v_step[v];
      wave = longint'(wave_at(v_phase[v])) * 26214 + longint'(wave_at({v_phase[v][14:0], 1'b0}))
          * 4915;
      mix += floor_div(wave * longint'(lvl) + (64'sd1 <<< 29), 30);
    end
    res = floor_div(mix * longint'(gain_q) + 64'sd16384, 15);
    s.clipped = 1'b0;
    if (res > 32767) begin
      res = 32767;
      s.clipped = 1'b1;
    end else if (res < -32768) begin
      res = -32768;
      s.clipped = 1'b1;
    end
    s.sample = res[15:0];
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s at sample %0d: got %0d, expected %0d", what, samples_seen, got,
             want);
    errors++;
  endtask

  // Driver: sends pending words with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        psv_out_t s;
        if (voice_engine_step(in_data, s)) expected_samples.push_back(s);
        pending_words.pop_front();
        words_sent <= words_sent + 1;
        send_gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0 || hold_off || pending_words.size() == 0 ||
            (in_valid && !in_stall && pending_words.size() == 0)) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_words[0];
        end
      end
    end
  end

  // Monitor: checks samples in order and stalls at random.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample", out_data.sample, 0);
        end else begin
          psv_out_t e;
          e = expected_samples.pop_front();
          if (out_data.sample !== e.sample)
            report_mismatch("sample", $signed(out_data.sample), $signed(e.sample));
          if (out_data.clipped !== e.clipped)
            report_mismatch("clipped", out_data.clipped, e.clipped);
        end
        stall_left = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) stall_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > MaxCycles) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input psv_cfg_e idx, input logic [14:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ATTACK: attack_q = val;
      CFG_RELEASE: release_q = val;
      default: gain_q = val;
    endcase
  endtask

  task automatic push_word(input psv_req_e r, input logic [7:0] k, input logic [15:0] st);
    psv_in_t w;
    w.req_type = r;
    w.key = k;
    w.phase_step = st;
    pending_words.push_back(w);
  endtask

  // Waits until the block has drained all work.
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // One phase of random traffic: mostly sensible note sequences.
  task automatic random_phase(input int n);
    logic [7:0] keys [4];
    int r;
    for (int k = 0; k < 4; k++) keys[k] = 8'($urandom);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) push_word(REQ_TICK, 8'($urandom), 16'($urandom));
      else if (r < 75) push_word(REQ_ON, keys[$urandom_range(0, 3)], 16'($urandom));
      else if (r < 90) push_word(REQ_OFF, keys[$urandom_range(0, 3)], 16'($urandom));
      else if (r < 95) push_word(psv_req_e'(2'd3), 8'($urandom), 16'($urandom));
      else push_word(psv_req_e'($urandom_range(1, 2)), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    for (int v = 0; v < NV; v++) begin
      v_phase[v] = '0;
      v_level[v] = '0;
      v_step[v] = '0;
      v_held[v] = 1'b0;
      v_owner[v] = '0;
    end
    attack_q = 15'd136;
    release_q = 15'd32745;
    gain_q = 15'd4915;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle release, idle tick, extremes, stealing, unused request.
    push_word(REQ_OFF, 8'd0, 16'd0);
    push_word(REQ_TICK, 8'd0, 16'd0);
    push_word(REQ_ON, 8'hFF, 16'hFFFF);
    push_word(REQ_ON, 8'hFF, 16'h1234);
    for (int k = 0; k < 9; k++) push_word(REQ_ON, 8'(k), 16'(k * 4000 + 1));
    push_word(psv_req_e'(2'd3), 8'hAA, 16'hFFFF);
    repeat (5) push_word(REQ_TICK, 8'h55, 16'h0);
    push_word(REQ_OFF, 8'hFF, 16'h0);
    push_word(REQ_OFF, 8'd3, 16'hFFFF);
    repeat (4) push_word(REQ_TICK, 8'hFF, 16'hFFFF);
    drain();

    // Fast attack, full gain for clipping, instant release to hit the floor.
    write_reg(CFG_ATTACK, 15'h7FFF);
    write_reg(CFG_GAIN, 15'h7FFF);
    write_reg(CFG_RELEASE, 15'd0);
    random_phase(250);
    drain();

    // Zero attack and zero gain.
    write_reg(CFG_ATTACK, 15'd0);
    write_reg(CFG_GAIN, 15'd0);
    write_reg(CFG_RELEASE, 15'h7FFF);
    random_phase(200);
    drain();

    // Defaults, with a pause midway until all samples come back.
    write_reg(CFG_ATTACK, 15'd136);
    write_reg(CFG_RELEASE, 15'd32745);
    write_reg(CFG_GAIN, 15'd4915);
    random_phase(300);
    while (pending_words.size() > 150) @(posedge clk);
    hold_off = 1'b1;
    @(posedge clk);
    while (in_valid || expected_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // Random register settings.
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_ATTACK, 15'($urandom));
      write_reg(CFG_RELEASE, 15'($urandom_range(20000, 32767)));
      write_reg(CFG_GAIN, 15'($urandom));
      random_phase(200);
      drain();
    end

    $display("Sent %0d words and checked %0d samples across fixed and random register settings.",
             words_sent, samples_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
